[src/ipt_pkg.sv]
// Package: shared widths, command codes, event codes and register indexes for the path tracker.
package ipt_pkg;

    localparam int POS_WIDTH_DEF   = 16;
    localparam int COUNT_WIDTH_DEF = 12;

    localparam int DIR_WIDTH   = 4;
    localparam int EVENT_WIDTH = 2;
    localparam int POINT_WIDTH = 17;
    localparam int MIN_WIDTH   = 16;
    localparam int MAX_WIDTH   = 15;
    localparam int SHIFT_WIDTH = 16;
    localparam int CFG_IDX_WIDTH = 1;

    typedef enum logic [DIR_WIDTH-1:0] {
        DIR_E    = 4'o01,
        DIR_W    = 4'o02,
        DIR_N    = 4'o04,
        DIR_NE   = 4'o05,
        DIR_NW   = 4'o06,
        DIR_S    = 4'o10,
        DIR_SE   = 4'o11,
        DIR_SW   = 4'o12,
        DIR_DOWN = 4'o14,
        DIR_UP   = 4'o16
    } dir_code_t;

    typedef enum logic [EVENT_WIDTH-1:0] {
        EV_NONE   = 2'd0,
        EV_START  = 2'd1,
        EV_LINE   = 2'd2,
        EV_STROKE = 2'd3
    } event_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_X_SHIFT = 1'b0,
        CFG_Y_SHIFT = 1'b1
    } cfg_index_t;

    localparam logic KIND_PLOT    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

endpackage

[src/ipt_if.sv]
// Interfaces: command, result and configuration channels of the path tracker.
interface ipt_cmd_if
    import ipt_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [DIR_WIDTH-1:0]   direction;
    logic [COUNT_WIDTH-1:0] step_count;

    modport source (output valid, kind, direction, step_count, input ready);
    modport sink   (input valid, kind, direction, step_count, output ready);
endinterface

interface ipt_res_if
    import ipt_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic [EVENT_WIDTH-1:0]        event_res;
    logic signed [POINT_WIDTH-1:0] point_x;
    logic signed [POINT_WIDTH-1:0] point_y;
    logic                          pen_down;
    logic signed [MIN_WIDTH-1:0]   min_x;
    logic [MAX_WIDTH-1:0]          max_x;
    logic signed [MIN_WIDTH-1:0]   min_y;
    logic [MAX_WIDTH-1:0]          max_y;
    logic                          bad_code;

    modport source (output valid, event_res, point_x, point_y, pen_down, min_x, max_x,
                    min_y, max_y, bad_code, input ready);
    modport sink   (input valid, event_res, point_x, point_y, pen_down, min_x, max_x,
                    min_y, max_y, bad_code, output ready);
endinterface

interface ipt_cfg_if
    import ipt_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_WIDTH-1:0] index;
    logic [SHIFT_WIDTH-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/incremental_plotter_path_tracker_top.sv]
// Top level: incremental plotter command interpreter with position and bounds tracking.
//
// Channels: cmd takes one plotter command per transfer (kind, direction, step_count);
// res gives exactly one result per command (event, shifted point, pen state, bounds,
// bad code flag); cfg writes x_shift (index 0) and y_shift (index 1), always ready.
// Latency: the result of a command is shown the cycle after its transfer.
// Throughput: one command per cycle unless a held result stalls cmd. Position, pen and bounds are updated by one
// add-and-saturate per axis plus bound compares in the transfer cycle; the result
// register takes the new point with the shift added.
// cmd.ready is high whenever the result register is empty or being drained, so a
// stalled receiver holds the pending result and blocks only further commands.
// Reset clears position, pen, drawing flag, bounds, shifts and the result valid flag.
// A restart command clears position, pen, drawing flag and bounds and reports it.
// Unknown direction codes in a plot command flag bad_code and leave all state unchanged.
module incremental_plotter_path_tracker_top
    import ipt_pkg::*;
#(
    parameter int POS_WIDTH   = POS_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)(
    input  logic clk,
    input  logic rst_n,
    ipt_cmd_if.sink   cmd,
    ipt_res_if.source res,
    ipt_cfg_if.sink   cfg
);

    // sum width for position plus or minus step
    localparam int SUM_W = ((POS_WIDTH > COUNT_WIDTH + 1) ? POS_WIDTH : COUNT_WIDTH + 2) + 1;
    // width for sign-extended position in output formatting
    localparam int EXT_W = (POS_WIDTH > POINT_WIDTH) ? POS_WIDTH : POINT_WIDTH;
    localparam int PT_W  = EXT_W + 1;

    localparam logic signed [SUM_W-1:0] POS_MAX =
        {{(SUM_W-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] POS_MIN = ~POS_MAX;

    logic [SHIFT_WIDTH-1:0] x_shift_reg;
    logic [SHIFT_WIDTH-1:0] y_shift_reg;

    logic signed [POS_WIDTH-1:0] pos_x_reg, pos_x_next;
    logic signed [POS_WIDTH-1:0] pos_y_reg, pos_y_next;
    logic signed [POS_WIDTH-1:0] low_x_reg, low_x_next;
    logic signed [POS_WIDTH-1:0] high_x_reg, high_x_next;
    logic signed [POS_WIDTH-1:0] low_y_reg, low_y_next;
    logic signed [POS_WIDTH-1:0] high_y_reg, high_y_next;
    logic pen_reg, pen_next;
    logic draw_reg, draw_next;

    logic                          out_valid_reg;
    event_t                        ev_reg, ev_next;
    logic signed [POINT_WIDTH-1:0] point_x_reg, point_x_next;
    logic signed [POINT_WIDTH-1:0] point_y_reg, point_y_next;
    logic                          bad_reg, bad_next;

    logic cmd_xfer;

    // decode
    logic move_x, neg_x, move_y, neg_y, dir_bad, pen_cmd, pen_val;
    logic signed [SUM_W-1:0] step_e, sum_x, sum_y, pos_x_e, pos_y_e;
    logic signed [POS_WIDTH-1:0] sat_x, sat_y;
    logic signed [PT_W-1:0] pt_x_wide, pt_y_wide;

    assign cmd.ready = !out_valid_reg || res.ready;
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        move_x  = 1'b0;
        neg_x   = 1'b0;
        move_y  = 1'b0;
        neg_y   = 1'b0;
        dir_bad = 1'b0;
        pen_cmd = 1'b0;
        pen_val = 1'b0;
        case (cmd.direction)
            DIR_N:    begin move_y = 1'b1; end
            DIR_NE:   begin move_y = 1'b1; move_x = 1'b1; end
            DIR_E:    begin move_x = 1'b1; end
            DIR_SE:   begin move_y = 1'b1; neg_y = 1'b1; move_x = 1'b1; end
            DIR_S:    begin move_y = 1'b1; neg_y = 1'b1; end
            DIR_SW:   begin move_y = 1'b1; neg_y = 1'b1; move_x = 1'b1; neg_x = 1'b1; end
            DIR_W:    begin move_x = 1'b1; neg_x = 1'b1; end
            DIR_NW:   begin move_y = 1'b1; move_x = 1'b1; neg_x = 1'b1; end
            DIR_UP:   begin pen_cmd = 1'b1; pen_val = 1'b0; end
            DIR_DOWN: begin pen_cmd = 1'b1; pen_val = 1'b1; end
            default:  begin dir_bad = 1'b1; end
        endcase
    end

    always_comb
    begin
        step_e  = SUM_W'({1'b0, cmd.step_count}) + SUM_W'(1);
        pos_x_e = SUM_W'(pos_x_reg);
        pos_y_e = SUM_W'(pos_y_reg);
        sum_x   = !move_x ? pos_x_e : (neg_x ? pos_x_e - step_e : pos_x_e + step_e);
        sum_y   = !move_y ? pos_y_e : (neg_y ? pos_y_e - step_e : pos_y_e + step_e);
        if (sum_x > POS_MAX)
            sat_x = POS_MAX[POS_WIDTH-1:0];
        else if (sum_x < POS_MIN)
            sat_x = POS_MIN[POS_WIDTH-1:0];
        else
            sat_x = sum_x[POS_WIDTH-1:0];
        if (sum_y > POS_MAX)
            sat_y = POS_MAX[POS_WIDTH-1:0];
        else if (sum_y < POS_MIN)
            sat_y = POS_MIN[POS_WIDTH-1:0];
        else
            sat_y = sum_y[POS_WIDTH-1:0];
    end

    always_comb
    begin
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        low_x_next  = low_x_reg;
        high_x_next = high_x_reg;
        low_y_next  = low_y_reg;
        high_y_next = high_y_reg;
        pen_next    = pen_reg;
        draw_next   = draw_reg;
        ev_next     = EV_NONE;
        bad_next    = 1'b0;
        if (cmd.kind == KIND_RESTART)
        begin
            pos_x_next  = '0;
            pos_y_next  = '0;
            low_x_next  = '0;
            high_x_next = '0;
            low_y_next  = '0;
            high_y_next = '0;
            pen_next    = 1'b0;
            draw_next   = 1'b0;
        end
        else if (dir_bad)
        begin
            bad_next = 1'b1;
        end
        else
        begin
            pos_x_next = sat_x;
            pos_y_next = sat_y;
            if (pen_cmd)
                pen_next = pen_val;
            if (sat_x > high_x_reg)
                high_x_next = sat_x;
            if (sat_x < low_x_reg)
                low_x_next = sat_x;
            if (sat_y > high_y_reg)
                high_y_next = sat_y;
            if (sat_y < low_y_reg)
                low_y_next = sat_y;
            if (pen_next != pen_reg)
            begin
                ev_next   = pen_next ? EV_START : EV_STROKE;
                draw_next = pen_next;
            end
            else if (draw_reg)
            begin
                ev_next = EV_LINE;
            end
        end
        pt_x_wide    = PT_W'(EXT_W'(pos_x_next)) + PT_W'({1'b0, x_shift_reg});
        pt_y_wide    = PT_W'(EXT_W'(pos_y_next)) + PT_W'({1'b0, y_shift_reg});
        point_x_next = pt_x_wide[POINT_WIDTH-1:0];
        point_y_next = pt_y_wide[POINT_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_shift_reg <= '0;
            y_shift_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_X_SHIFT: x_shift_reg <= cfg.data;
                CFG_Y_SHIFT: y_shift_reg <= cfg.data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            low_x_reg  <= '0;
            high_x_reg <= '0;
            low_y_reg  <= '0;
            high_y_reg <= '0;
            pen_reg    <= 1'b0;
            draw_reg   <= 1'b0;
        end
        else if (cmd_xfer)
        begin
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            low_x_reg  <= low_x_next;
            high_x_reg <= high_x_next;
            low_y_reg  <= low_y_next;
            high_y_reg <= high_y_next;
            pen_reg    <= pen_next;
            draw_reg   <= draw_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd_xfer)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    // result payload, loaded on command transfer
    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            ev_reg      <= ev_next;
            point_x_reg <= point_x_next;
            point_y_reg <= point_y_next;
            bad_reg     <= bad_next;
        end
    end

    logic signed [EXT_W-1:0] low_x_ext, high_x_ext, low_y_ext, high_y_ext;

    assign low_x_ext  = EXT_W'(low_x_reg);
    assign high_x_ext = EXT_W'(high_x_reg);
    assign low_y_ext  = EXT_W'(low_y_reg);
    assign high_y_ext = EXT_W'(high_y_reg);

    // bounds and pen only change on transfer, so the registers double as result fields
    assign res.valid     = out_valid_reg;
    assign res.event_res = ev_reg;
    assign res.point_x   = point_x_reg;
    assign res.point_y   = point_y_reg;
    assign res.pen_down  = pen_reg;
    assign res.min_x     = low_x_ext[MIN_WIDTH-1:0];
    assign res.max_x     = high_x_ext[MAX_WIDTH-1:0];
    assign res.min_y     = low_y_ext[MIN_WIDTH-1:0];
    assign res.max_y     = high_y_ext[MAX_WIDTH-1:0];
    assign res.bad_code  = bad_reg;

    a_bad_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.bad_code |-> res.event_res == EV_NONE)
        else $error("bad code result carries an event");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready && cmd.kind == KIND_RESTART |=>
        res.valid && !res.pen_down && low_x_reg == '0 && high_y_reg == '0)
        else $error("restart did not clear tracking state");

    a_start_pen_down: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.event_res == EV_START |-> res.pen_down && draw_reg)
        else $error("path start without pen down");

    a_pos_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        low_x_reg <= pos_x_reg && pos_x_reg <= high_x_reg &&
        low_y_reg <= pos_y_reg && pos_y_reg <= high_y_reg)
        else $error("position outside bounding box");

endmodule
